>>> hw/rtl/rtac_pkg.sv
`timescale 1ns / 1ps
// Package for the region table access checker: codes, kind bits and the
// item record that travels along the row of region cells. No dependencies.
package rtac_pkg;

   localparam int ADDR_W = 32;
   localparam int KIND_W = 3;

   // Command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   // Access modes
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;

   // Bit positions in a region kind
   localparam int KIND_STACK = 0;
   localparam int KIND_READ  = 1;
   localparam int KIND_WRITE = 2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // Item record handed from cell to cell
   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] end_addr;  // addr + length, wrapped
      logic [ADDR_W-1:0] low_addr;  // addr - length, wrapped
      logic [KIND_W-1:0] kind;
      logic [1:0]        mode;
      logic              reject;    // add: rejected so far
      logic              placed;    // add: written into a free cell
      logic              hit_a;     // start matched some earlier cell
      logic              hit_e;     // end matched some earlier cell
      logic              same;      // first match of start and end is one cell
      logic              grant;     // that cell grants the requested mode
   } pkt_type;

endpackage

>>> hw/rtl/rtac_cell.sv
`timescale 1ns / 1ps
// One region cell: holds one table entry, tests the passing item against it
// and hands the item to the next cell. Depends on rtac_pkg.
module rtac_cell #(
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_W-1:0]      count_i,
   input  logic                  active_i,
   input  rtac_pkg::pkt_type     pkt_i,
   output logic                  active_o,
   output rtac_pkg::pkt_type     pkt_o
);
   import rtac_pkg::*;

   logic [ADDR_W-1:0] base_ff, sum_ff, diff_ff;
   logic [KIND_W-1:0] kind_ff;
   logic              active_ff;
   pkt_type           pkt_ff, pkt_in;
   logic              used, slot, hit_a, hit_e, encl, write_en;

   function automatic logic covers(input logic [ADDR_W-1:0] x,
                                   input logic [ADDR_W-1:0] b,
                                   input logic [ADDR_W-1:0] s,
                                   input logic [ADDR_W-1:0] d,
                                   input logic              stack);
      logic r;
      if (!stack) begin
         r = (x >= b) && (x < s);
      end else begin
         r = (x <= b) && (x > d);
      end
      return r;
   endfunction

   always_comb begin
      used     = count_i > CNT_W'(INDEX);
      slot     = count_i == CNT_W'(INDEX);
      hit_a    = used && covers(pkt_i.addr, base_ff, sum_ff, diff_ff, kind_ff[KIND_STACK]);
      hit_e    = used && covers(pkt_i.end_addr, base_ff, sum_ff, diff_ff,
                                kind_ff[KIND_STACK]);
      encl     = used && (pkt_i.addr < base_ff) && (pkt_i.end_addr > sum_ff);
      write_en = active_i && (pkt_i.cmd == CMD_ADD) && slot && !pkt_i.reject;

      pkt_in = pkt_i;
      if (pkt_i.cmd == CMD_ADD) begin
         pkt_in.reject = pkt_i.reject | hit_a | hit_e | encl;
         if (write_en) begin
            pkt_in.placed = 1'b1;
         end
      end else begin
         // first match for the start; record whether the end matches here too
         if (!pkt_i.hit_a && hit_a && !pkt_i.hit_e && hit_e) begin
            pkt_in.same  = 1'b1;
            pkt_in.grant = ((pkt_i.mode == MODE_READ) && kind_ff[KIND_READ]) ||
                           ((pkt_i.mode == MODE_WRITE) && kind_ff[KIND_WRITE]);
         end
      end
      pkt_in.hit_a = pkt_i.hit_a | hit_a;
      pkt_in.hit_e = pkt_i.hit_e | hit_e;
   end

   // entry storage: written once, when an accepted add reaches the free slot
   always_ff @(posedge clock) begin
      if (write_en) begin
         base_ff <= pkt_i.addr;
         sum_ff  <= pkt_i.end_addr;
         diff_ff <= pkt_i.low_addr;
         kind_ff <= pkt_i.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_i;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign active_o = active_ff;
   assign pkt_o    = pkt_ff;

endmodule

>>> hw/rtl/region_table_access_checker_top.sv
`timescale 1ns / 1ps
// Region table access checker, top level. An accepted item passes the entry
// stage register, then the register of each region cell in turn, one cell per
// cycle, and then the status register that drives the strobe. A new item is
// taken only once the current one has left the last cell (busy).
// The receiver cannot stall the strobe.
// Reset empties the table (count to zero) and sets top_limit to all ones.
// Depends on rtac_pkg and rtac_cell.
module region_table_access_checker_top #(
   parameter int REGION_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [31:0] req_addr,
   input  logic [31:0] req_length,
   input  logic        req_is_stack,
   input  logic        req_can_read,
   input  logic        req_can_write,
   input  logic [1:0]  req_access_mode,
   // result output
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   // top_limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);
   import rtac_pkg::*;

   localparam int CNT_W = $clog2(REGION_ENTRIES + 1);

   logic                accept;
   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   top_limit_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff, rsp_status_in;

   // chain[0] is the entry stage, chain[i+1] the output of cell i
   logic                active_chain [0:REGION_ENTRIES];
   pkt_type             pkt_chain    [0:REGION_ENTRIES];
   logic                entry_active_ff;
   pkt_type             entry_pkt_ff, entry_pkt_in;
   pkt_type             last_pkt;
   logic                last_active;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   // Configuration: user writes only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         top_limit_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         top_limit_ff <= csr_wdata;
      end
   end

   // Entry stage: form both ends of the range and the checks that need no table
   always_comb begin
      entry_pkt_in          = '0;
      entry_pkt_in.cmd      = req_cmd;
      entry_pkt_in.addr     = req_addr;
      entry_pkt_in.end_addr = req_addr + req_length;
      entry_pkt_in.low_addr = req_addr - req_length;
      entry_pkt_in.kind     = {req_can_write, req_can_read, req_is_stack};
      entry_pkt_in.mode     = req_access_mode;
      // zero start, start past the limit, or upward region ending past it
      entry_pkt_in.reject   = (req_addr == '0) || (req_addr > top_limit_ff) ||
                              (!req_is_stack && (entry_pkt_in.end_addr > top_limit_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_active_ff <= 1'b0;
      end else begin
         entry_active_ff <= accept;
      end
   end

   // Hold the item payload until the next accept
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_pkt_ff <= entry_pkt_in;
      end
   end

   assign active_chain[0] = entry_active_ff;
   assign pkt_chain[0]    = entry_pkt_ff;

   // Row of region cells; cell i holds table entry i
   for (genvar i = 0; i < REGION_ENTRIES; i++) begin : g_cell
      rtac_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .count_i  (count_ff),
         .active_i (active_chain[i]),
         .pkt_i    (pkt_chain[i]),
         .active_o (active_chain[i+1]),
         .pkt_o    (pkt_chain[i+1])
      );
   end

   assign last_active = active_chain[REGION_ENTRIES];
   assign last_pkt    = pkt_chain[REGION_ENTRIES];

   // Final status once the item has passed every cell
   always_comb begin
      if (last_pkt.cmd == CMD_ADD) begin
         if (last_pkt.reject) begin
            rsp_status_in = ST_REJECT;
         end else if (last_pkt.placed) begin
            rsp_status_in = ST_OK;
         end else begin
            rsp_status_in = ST_FULL;
         end
      end else begin
         // both ends must match, first match is the same cell, mode granted
         if (last_pkt.hit_a && last_pkt.hit_e && last_pkt.same && last_pkt.grant) begin
            rsp_status_in = ST_OK;
         end else begin
            rsp_status_in = ST_REJECT;
         end
      end
   end

   // Busy from accept until the item leaves the last cell; count the new entry
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (last_active) begin
         busy_in = 1'b0;
         if ((last_pkt.cmd == CMD_ADD) && !last_pkt.reject && last_pkt.placed) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= last_active;
      end
   end

   always_ff @(posedge clock) begin
      if (last_active) begin
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // Assertions
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accept");

   a_idle_on_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff || $past(accept))
      else $error("result strobe while item still in flight");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(REGION_ENTRIES))
      else $error("region count past table size");

   a_count_on_ok : assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> rsp_valid_ff && (rsp_status_ff == ST_OK)
                            && (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("region count changed without an accepted add");

endmodule
